[rtl/core/cau_pkg.sv]
package cau_pkg;

	// Operation codes carried by each request.
	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_NEG   = 3'd1,
		CMD_MUL   = 3'd2,
		CMD_DIV   = 3'd3,
		CMD_FIXUP = 3'd4
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SAT     = 2'd1,
		ST_DIVZERO = 2'd2
	} status_t;

	// Width and reset value of the fixup shift register.
	localparam int SHIFT_W = 5;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd24;

	// Control group that travels down the pipeline with each request.
	typedef struct packed {
		logic    valid;
		cmd_t    cmd;
		logic    neg_re;
		logic    neg_im;
		logic    divzero;
		status_t status;
		logic    zeroed;
	} ctrl_t;

endpackage

[rtl/core/cau_front.sv]
module cau_front import cau_pkg::*; #(
	parameter int DW = 32,
	parameter int FB = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [2:0]             command,
	input  logic signed [DW-1:0]   a_re,
	input  logic signed [DW-1:0]   a_im,
	input  logic signed [DW-1:0]   b_re,
	input  logic signed [DW-1:0]   b_im,
	input  logic [SHIFT_W-1:0]     shift,
	output ctrl_t                  ctrl_s3,
	output logic signed [DW-1:0]   e_re_s3,
	output logic signed [DW-1:0]   e_im_s3,
	output logic [2*DW-1:0]        den_s3,
	output logic [3*DW+FB+1:0]     rem_re_s3,
	output logic [3*DW+FB+1:0]     rem_im_s3
);

	localparam int PW = 2 * DW;
	localparam int CW = 3 * DW + FB + 2;
	localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [PW:0] BIAS = (PW+1)'((1 << FB) - 1);

	// Stage one registers.
	ctrl_t                 ctrl_s1;
	logic signed [DW-1:0]  e_re_s1, e_im_s1;
	logic signed [PW-1:0]  p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic [PW-1:0]         d_r_s1, d_i_s1;

	// Stage two registers.
	ctrl_t                 ctrl_s2;
	logic signed [DW-1:0]  e_re_s2, e_im_s2;
	logic signed [PW:0]    x_re_s2, x_im_s2;
	logic [PW-1:0]         den_s2;

	// Short operations finish in stage one; products start here.
	logic signed [DW:0]  add_re, add_im, neg_re, neg_im;
	logic [DW-1:0]       mag_re, mag_im;
	logic signed [DW-1:0] r_re_c, r_im_c;
	logic                sat_re_c, sat_im_c;
	ctrl_t               ctrl_c;

	always_comb begin
		add_re = {a_re[DW-1], a_re} + {b_re[DW-1], b_re};
		add_im = {a_im[DW-1], a_im} + {b_im[DW-1], b_im};
		neg_re = -{a_re[DW-1], a_re};
		neg_im = -{a_im[DW-1], a_im};
		mag_re = a_re[DW-1] ? -a_re : a_re;
		mag_im = a_im[DW-1] ? -a_im : a_im;
		r_re_c = '0;
		r_im_c = '0;
		sat_re_c = 1'b0;
		sat_im_c = 1'b0;
		ctrl_c = '0;
		ctrl_c.valid = accept;
		ctrl_c.cmd = cmd_t'(command);
		ctrl_c.divzero = (b_re == '0) && (b_im == '0);
		case (cmd_t'(command))
			CMD_ADD: begin
				sat_re_c = add_re[DW] != add_re[DW-1];
				sat_im_c = add_im[DW] != add_im[DW-1];
				r_re_c = sat_re_c ? (add_re[DW] ? VMIN : VMAX) : add_re[DW-1:0];
				r_im_c = sat_im_c ? (add_im[DW] ? VMIN : VMAX) : add_im[DW-1:0];
			end
			CMD_NEG: begin
				sat_re_c = neg_re[DW] != neg_re[DW-1];
				sat_im_c = neg_im[DW] != neg_im[DW-1];
				r_re_c = sat_re_c ? (neg_re[DW] ? VMIN : VMAX) : neg_re[DW-1:0];
				r_im_c = sat_im_c ? (neg_im[DW] ? VMIN : VMAX) : neg_im[DW-1:0];
			end
			CMD_FIXUP: begin
				r_re_c = a_re;
				r_im_c = a_im;
				if ((mag_re >> shift) > mag_im) begin
					r_im_c = '0;
					ctrl_c.zeroed = 1'b1;
				end else if ((mag_im >> shift) > mag_re) begin
					r_re_c = '0;
					ctrl_c.zeroed = 1'b1;
				end
			end
			CMD_DIV: begin
				if (ctrl_c.divzero) begin
					ctrl_c.status = ST_DIVZERO;
				end
			end
			default: begin
				r_re_c = '0;
				r_im_c = '0;
			end
		endcase
		if (sat_re_c || sat_im_c) begin
			ctrl_c.status = ST_SAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_c;
		end
	end

	always_ff @(posedge clk) begin
		e_re_s1 <= r_re_c;
		e_im_s1 <= r_im_c;
		p_rr_s1 <= a_re * b_re;
		p_ii_s1 <= a_im * b_im;
		p_ri_s1 <= a_re * b_im;
		p_ir_s1 <= a_im * b_re;
		d_r_s1  <= PW'(b_re * b_re);
		d_i_s1  <= PW'(b_im * b_im);
	end

	// Stage two forms the sums of products and the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		e_re_s2 <= e_re_s1;
		e_im_s2 <= e_im_s1;
		den_s2  <= d_r_s1 + d_i_s1;
		if (ctrl_s1.cmd == CMD_MUL) begin
			x_re_s2 <= {p_rr_s1[PW-1], p_rr_s1} - {p_ii_s1[PW-1], p_ii_s1};
			x_im_s2 <= {p_ri_s1[PW-1], p_ri_s1} + {p_ir_s1[PW-1], p_ir_s1};
		end else begin
			x_re_s2 <= {p_rr_s1[PW-1], p_rr_s1} + {p_ii_s1[PW-1], p_ii_s1};
			x_im_s2 <= {p_ir_s1[PW-1], p_ir_s1} - {p_ri_s1[PW-1], p_ri_s1};
		end
	end

	// Stage three truncates and clips products, or sets up the dividends.
	logic signed [PW:0]   t_re, t_im;
	logic [PW:0]          n_re, n_im;
	logic                 ov_re, ov_im;
	logic signed [DW-1:0] m_re, m_im;
	ctrl_t                ctrl3_c;

	always_comb begin
		t_re = $signed(x_re_s2 + (x_re_s2[PW] ? BIAS : '0)) >>> FB;
		t_im = $signed(x_im_s2 + (x_im_s2[PW] ? BIAS : '0)) >>> FB;
		ov_re = !((&t_re[PW:DW-1]) || !(|t_re[PW:DW-1]));
		ov_im = !((&t_im[PW:DW-1]) || !(|t_im[PW:DW-1]));
		m_re = ov_re ? (t_re[PW] ? VMIN : VMAX) : t_re[DW-1:0];
		m_im = ov_im ? (t_im[PW] ? VMIN : VMAX) : t_im[DW-1:0];
		n_re = x_re_s2[PW] ? -x_re_s2 : x_re_s2;
		n_im = x_im_s2[PW] ? -x_im_s2 : x_im_s2;
		ctrl3_c = ctrl_s2;
		ctrl3_c.neg_re = x_re_s2[PW];
		ctrl3_c.neg_im = x_im_s2[PW];
		if (ctrl_s2.cmd == CMD_MUL && (ov_re || ov_im)) begin
			ctrl3_c.status = ST_SAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else begin
			ctrl_s3 <= ctrl3_c;
		end
	end

	always_ff @(posedge clk) begin
		e_re_s3   <= (ctrl_s2.cmd == CMD_MUL) ? m_re : e_re_s2;
		e_im_s3   <= (ctrl_s2.cmd == CMD_MUL) ? m_im : e_im_s2;
		den_s3    <= den_s2;
		rem_re_s3 <= CW'(n_re) << FB;
		rem_im_s3 <= CW'(n_im) << FB;
	end

endmodule

[rtl/core/cau_div_step.sv]
module cau_div_step import cau_pkg::*; #(
	parameter int DW = 32,
	parameter int FB = 16,
	parameter int K  = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_t                 ctrl_i,
	input  logic signed [DW-1:0]  e_re_i,
	input  logic signed [DW-1:0]  e_im_i,
	input  logic [2*DW-1:0]       den_i,
	input  logic [3*DW+FB+1:0]    rem_re_i,
	input  logic [3*DW+FB+1:0]    rem_im_i,
	input  logic [DW+1:0]         q_re_i,
	input  logic [DW+1:0]         q_im_i,
	output ctrl_t                 ctrl_o,
	output logic signed [DW-1:0]  e_re_o,
	output logic signed [DW-1:0]  e_im_o,
	output logic [2*DW-1:0]       den_o,
	output logic [3*DW+FB+1:0]    rem_re_o,
	output logic [3*DW+FB+1:0]    rem_im_o,
	output logic [DW+1:0]         q_re_o,
	output logic [DW+1:0]         q_im_o
);

	localparam int CW = 3 * DW + FB + 2;

	// One restoring step: try the divisor aligned to quotient bit K.
	logic [CW-1:0] dk;
	logic          ge_re, ge_im;

	always_comb begin
		dk = CW'(den_i) << K;
		ge_re = rem_re_i >= dk;
		ge_im = rem_im_i >= dk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_o <= '0;
		end else begin
			ctrl_o <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		e_re_o   <= e_re_i;
		e_im_o   <= e_im_i;
		den_o    <= den_i;
		rem_re_o <= ge_re ? rem_re_i - dk : rem_re_i;
		rem_im_o <= ge_im ? rem_im_i - dk : rem_im_i;
		q_re_o   <= {q_re_i[DW:0], ge_re};
		q_im_o   <= {q_im_i[DW:0], ge_im};
	end

endmodule

[rtl/core/cau_back.sv]
module cau_back import cau_pkg::*; #(
	parameter int DW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_t                 ctrl_i,
	input  logic signed [DW-1:0]  e_re_i,
	input  logic signed [DW-1:0]  e_im_i,
	input  logic [DW+1:0]         q_re_i,
	input  logic [DW+1:0]         q_im_i,
	output logic                  done,
	output logic signed [DW-1:0]  r_re,
	output logic signed [DW-1:0]  r_im,
	output logic [1:0]            status,
	output logic                  part_zeroed
);

	localparam int QW = DW + 2;
	localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [QW-1:0] LIM_NEG = QW'(1) << (DW - 1);
	localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

	// Sign and clip the quotients, then pick the result for the command.
	logic                 sat_re, sat_im, use_q;
	logic signed [DW-1:0] v_re, v_im;
	status_t              st_c;

	always_comb begin
		sat_re = q_re_i > (ctrl_i.neg_re ? LIM_NEG : LIM_POS);
		sat_im = q_im_i > (ctrl_i.neg_im ? LIM_NEG : LIM_POS);
		v_re = sat_re ? (ctrl_i.neg_re ? VMIN : VMAX)
			: (ctrl_i.neg_re ? -q_re_i[DW-1:0] : q_re_i[DW-1:0]);
		v_im = sat_im ? (ctrl_i.neg_im ? VMIN : VMAX)
			: (ctrl_i.neg_im ? -q_im_i[DW-1:0] : q_im_i[DW-1:0]);
		use_q = (ctrl_i.cmd == CMD_DIV) && !ctrl_i.divzero;
		st_c = ctrl_i.status;
		if (use_q && (sat_re || sat_im)) begin
			st_c = ST_SAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		r_re        <= use_q ? v_re : e_re_i;
		r_im        <= use_q ? v_im : e_im_i;
		status      <= st_c;
		part_zeroed <= ctrl_i.zeroed;
	end

endmodule

[rtl/core/complex_arith_unit.sv]
// Complex arithmetic unit on signed fixed-point operands. A request is taken
// on every clock edge at which start is high; busy is always low, so a new
// request may follow in every cycle. Each request gives exactly one result,
// marked by done for one cycle, and every command takes the same path
// through the pipeline: three stages of multiply, sum and set-up, then the
// divider with one restoring step per quotient bit, DATA_WIDTH + 2 steps,
// then one output stage. Results appear in request order and the receiver
// cannot stall them, so it must take done whenever it is high. The user must
// write the fixup shift through cfg_we and cfg_data only while no request is
// in flight; the block itself does not enforce this.
module complex_arith_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [SHIFT_W-1:0]           cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   command,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] r_re,
	output logic signed [DATA_WIDTH-1:0] r_im,
	output logic [1:0]                   status,
	output logic                         part_zeroed
);

	localparam int DW = DATA_WIDTH;
	localparam int CW = 3 * DW + FRAC_BITS + 2;
	localparam int NS = DW + 2;

	// Fixup shift register.
	logic [SHIFT_W-1:0] shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SHIFT_RESET;
		end else if (cfg_we) begin
			shift_q <= cfg_data;
		end
	end

	// The pipeline never stalls.
	assign busy = 1'b0;

	// Links between the divider steps.
	ctrl_t                 ctrl_c [0:NS];
	logic signed [DW-1:0]  e_re_c [0:NS];
	logic signed [DW-1:0]  e_im_c [0:NS];
	logic [2*DW-1:0]       den_c  [0:NS];
	logic [CW-1:0]         rre_c  [0:NS];
	logic [CW-1:0]         rim_c  [0:NS];
	logic [DW+1:0]         qre_c  [0:NS];
	logic [DW+1:0]         qim_c  [0:NS];

	// Multiply, sum and set-up stages.
	cau_front #(.DW(DW), .FB(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (start && !busy),
		.command   (command),
		.a_re      (a_re),
		.a_im      (a_im),
		.b_re      (b_re),
		.b_im      (b_im),
		.shift     (shift_q),
		.ctrl_s3   (ctrl_c[0]),
		.e_re_s3   (e_re_c[0]),
		.e_im_s3   (e_im_c[0]),
		.den_s3    (den_c[0]),
		.rem_re_s3 (rre_c[0]),
		.rem_im_s3 (rim_c[0])
	);

	assign qre_c[0] = '0;
	assign qim_c[0] = '0;

	// Divider steps, most significant quotient bit first.
	for (genvar i = 0; i < NS; i++) begin : g_div
		cau_div_step #(.DW(DW), .FB(FRAC_BITS), .K(NS - 1 - i)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl_i   (ctrl_c[i]),
			.e_re_i   (e_re_c[i]),
			.e_im_i   (e_im_c[i]),
			.den_i    (den_c[i]),
			.rem_re_i (rre_c[i]),
			.rem_im_i (rim_c[i]),
			.q_re_i   (qre_c[i]),
			.q_im_i   (qim_c[i]),
			.ctrl_o   (ctrl_c[i+1]),
			.e_re_o   (e_re_c[i+1]),
			.e_im_o   (e_im_c[i+1]),
			.den_o    (den_c[i+1]),
			.rem_re_o (rre_c[i+1]),
			.rem_im_o (rim_c[i+1]),
			.q_re_o   (qre_c[i+1]),
			.q_im_o   (qim_c[i+1])
		);
	end

	// Result selection and output register.
	cau_back #(.DW(DW)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl_i      (ctrl_c[NS]),
		.e_re_i      (e_re_c[NS]),
		.e_im_i      (e_im_c[NS]),
		.q_re_i      (qre_c[NS]),
		.q_im_i      (qim_c[NS]),
		.done        (done),
		.r_re        (r_re),
		.r_im        (r_im),
		.status      (status),
		.part_zeroed (part_zeroed)
	);

endmodule

[verif/tb.sv]
module tb;
	import cau_pkg::*;

	localparam int W = 32;
	localparam int LIMIT = 400000;
	localparam int DRAIN = 48;
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam logic signed [W-1:0] VMAX = 32'sh7fff_ffff;
	localparam logic signed [W-1:0] VMIN = 32'sh8000_0000;

	// One predicted result of the arithmetic unit.
	typedef struct {
		logic signed [W-1:0] re;
		logic signed [W-1:0] im;
		status_t             st;
		logic                zeroed;
	} cplx_result_t;

	// Holds the fixup shift, predicts each request and checks results in order.
	class cplx_scoreboard;
		cplx_result_t pending[$];
		logic [SHIFT_W-1:0] ratio_shift = SHIFT_RESET;
		int n_fail = 0;
		int n_checked = 0;

		// Clamps an exact value to the field range, flagging saturation.
		function automatic logic signed [W-1:0] clamp(input logic signed [127:0] v,
				inout bit sat);
			if (v > 128'(VMAX)) begin
				sat = 1;
				return VMAX;
			end
			if (v < 128'(VMIN)) begin
				sat = 1;
				return VMIN;
			end
			return v[W-1:0];
		endfunction

		function automatic logic signed [127:0] mag(input logic signed [127:0] v);
			return (v < 0) ? -v : v;
		endfunction

		// Drops the fraction bits of a double-precision product, toward zero.
		function automatic logic signed [127:0] trunc_frac(input logic signed [127:0] v);
			return (v < 0) ? -(mag(v) >>> 16) : (v >>> 16);
		endfunction

		// Quotient of (num << 16) by den, truncated toward zero.
		function automatic logic signed [127:0] quot(input logic signed [127:0] num,
				input logic signed [127:0] den);
			logic signed [127:0] q;
			q = (mag(num) <<< 16) / den;
			return (num < 0) ? -q : q;
		endfunction

		function void note(input logic [2:0] cmd, input logic signed [W-1:0] ar,
				input logic signed [W-1:0] ai, input logic signed [W-1:0] br,
				input logic signed [W-1:0] bi);
			logic signed [127:0] xr, xi, yr, yi, er, ei, den;
			cplx_result_t res;
			bit sat;
			xr = ar;
			xi = ai;
			yr = br;
			yi = bi;
			er = 0;
			ei = 0;
			sat = 0;
			res.st = ST_OK;
			res.zeroed = 0;
			case (cmd)
				CMD_ADD: begin
					er = xr + yr;
					ei = xi + yi;
				end
				CMD_NEG: begin
					er = -xr;
					ei = -xi;
				end
				CMD_MUL: begin
					er = trunc_frac(xr * yr - xi * yi);
					ei = trunc_frac(xr * yi + xi * yr);
				end
				CMD_DIV: begin
					den = yr * yr + yi * yi;
					if (den == 0) begin
						res.st = ST_DIVZERO;
					end else begin
						er = quot(xr * yr + xi * yi, den);
						ei = quot(xi * yr - xr * yi, den);
					end
				end
				CMD_FIXUP: begin
					er = xr;
					ei = xi;
					if ((mag(xr) >>> ratio_shift) > mag(xi)) begin
						ei = 0;
						res.zeroed = 1;
					end else if ((mag(xi) >>> ratio_shift) > mag(xr)) begin
						er = 0;
						res.zeroed = 1;
					end
				end
				default: begin
				end
			endcase
			res.re = clamp(er, sat);
			res.im = clamp(ei, sat);
			if (res.st == ST_OK && sat)
				res.st = ST_SAT;
			pending.push_back(res);
		endfunction

		function void check(input logic signed [W-1:0] re, input logic signed [W-1:0] im,
				input logic [1:0] st, input logic zeroed);
			cplx_result_t exp_res;
			if (pending.size() == 0) begin
				$error("result with no request outstanding: r_re=%0d r_im=%0d", re, im);
				n_fail++;
				return;
			end
			exp_res = pending.pop_front();
			n_checked++;
			if (re !== exp_res.re) begin
				$error("r_re: expected %0d, got %0d", exp_res.re, re);
				n_fail++;
			end
			if (im !== exp_res.im) begin
				$error("r_im: expected %0d, got %0d", exp_res.im, im);
				n_fail++;
			end
			if (st !== exp_res.st) begin
				$error("status: expected %0d, got %0d", exp_res.st, st);
				n_fail++;
			end
			if (zeroed !== exp_res.zeroed) begin
				$error("part_zeroed: expected %0d, got %0d", exp_res.zeroed, zeroed);
				n_fail++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [SHIFT_W-1:0] cfg_data = '0;
	logic start = 0;
	logic busy;
	logic [2:0] command = '0;
	logic signed [W-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic done;
	logic signed [W-1:0] r_re, r_im;
	logic [1:0] status;
	logic part_zeroed;

	cplx_scoreboard sb = new();
	int cycles = 0;
	int idle_pct = 0;
	int n_sent = 0;
	int shifts_used = 0;

	complex_arith_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.start(start), .busy(busy), .command(command),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.done(done), .r_re(r_re), .r_im(r_im), .status(status),
		.part_zeroed(part_zeroed)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Note accepted requests and check results on every rising edge.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note(command, a_re, a_im, b_re, b_im);
		if (arst_n && done)
			sb.check(r_re, r_im, status, part_zeroed);
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Presents one request and holds it until the unit takes it.
	task automatic send_req(input logic [2:0] cmd, input logic signed [W-1:0] ar,
			input logic signed [W-1:0] ai, input logic signed [W-1:0] br,
			input logic signed [W-1:0] bi);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		command <= cmd;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		n_sent++;
	endtask

	// Lets all outstanding results arrive, then idles before returning.
	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_shift(input logic [SHIFT_W-1:0] s);
		cfg_we <= 1;
		cfg_data <= s;
		@(posedge clk);
		cfg_we <= 0;
		sb.ratio_shift = s;
		shifts_used++;
	endtask

	// Operand mix: wide random values, small Q16.16 values and the extremes.
	function automatic logic signed [W-1:0] pick_val();
		case ($urandom_range(7))
			0: return VMAX;
			1: return VMIN;
			2: return '0;
			3, 4: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_block(input int count);
		logic signed [W-1:0] ar, ai, br, bi;
		logic [2:0] cmd;
		for (int i = 0; i < count; i++) begin
			cmd = $urandom_range(0, 7);
			if (cmd > CMD_SPARE_LO && $urandom_range(1))
				cmd = CMD_FIXUP;
			ar = pick_val();
			ai = pick_val();
			br = pick_val();
			bi = pick_val();
			// Fixup near its threshold: one part a shifted copy of the other.
			if (cmd == CMD_FIXUP && $urandom_range(1)) begin
				if ($urandom_range(1))
					ai = (ar >>> $urandom_range(0, 31)) + $signed($urandom_range(0, 2)) - 1;
				else
					ar = (ai >>> $urandom_range(0, 31)) + $signed($urandom_range(0, 2)) - 1;
			end
			if (cmd == CMD_DIV && $urandom_range(9) == 0) begin
				br = '0;
				bi = '0;
			end
			send_req(cmd, ar, ai, br, bi);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed requests at the reset shift: extremes, every command, corner cases.
		send_req(CMD_ADD, VMAX, VMIN, VMAX, VMIN);
		send_req(CMD_ADD, 32'sh0001_0000, -32'sh0002_8000, 32'sh0000_8000, 32'sh0001_0000);
		send_req(CMD_NEG, VMIN, VMAX, '0, '0);
		send_req(CMD_NEG, '0, -32'sh0001_0000, VMAX, VMIN);
		send_req(CMD_MUL, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_8000, 32'sh0000_4000);
		send_req(CMD_MUL, VMIN, VMIN, VMIN, VMIN);
		send_req(CMD_MUL, VMAX, VMIN, VMAX, VMAX);
		send_req(CMD_MUL, -32'sh1, 32'sh1, 32'sh1, 32'sh1);
		send_req(CMD_DIV, 32'sh0004_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000);
		send_req(CMD_DIV, VMAX, VMIN, '0, '0);
		send_req(CMD_DIV, VMAX, VMAX, 32'sh1, '0);
		send_req(CMD_DIV, VMIN, VMIN, VMIN, VMIN);
		send_req(CMD_DIV, -32'sh7, 32'sh3, '0, -32'sh0000_0002);
		send_req(CMD_FIXUP, 32'sh4000_0000, 32'sh0000_0001, '0, '0);
		send_req(CMD_FIXUP, 32'sh0000_0001, VMIN, '0, '0);
		send_req(CMD_FIXUP, 32'sh0100_0000, 32'sh0000_0001, '0, '0);
		send_req(CMD_FIXUP, 32'sh0000_1234, 32'sh0000_5678, '0, '0);
		send_req(CMD_FIXUP, '0, '0, '0, '0);
		send_req(CMD_SPARE_LO, VMAX, VMIN, VMAX, VMIN);
		send_req(CMD_SPARE_HI, -32'sh1, -32'sh1, -32'sh1, -32'sh1);
		drain();

		// Shift of zero: fixup zeroes the strictly smaller part.
		write_shift('0);
		send_req(CMD_FIXUP, 32'sh0000_0005, -32'sh0000_0004, '0, '0);
		send_req(CMD_FIXUP, 32'sh0000_0005, -32'sh0000_0005, '0, '0);
		send_req(CMD_FIXUP, VMIN, VMAX, '0, '0);

		// Random traffic through several shifts and three idling profiles.
		for (int blk = 0; blk < 6; blk++) begin
			drain();
			case (blk)
				0: write_shift(5'd1);
				1: write_shift(5'd31);
				2: write_shift('0);
				default: write_shift($urandom_range(1, 31));
			endcase
			idle_pct = (blk < 2) ? 13 : (blk < 4) ? 51 : 0;
			random_block(250);
		end
		idle_pct = 0;
		drain();

		$display("Sent %0d requests, checked %0d results.", n_sent, sb.n_checked);
		$display("Covered all commands, spare codes, zero divisors and %0d shift writes.",
			shifts_used);
		if (sb.n_fail == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_div_step.sv
rtl/core/cau_back.sv
rtl/core/complex_arith_unit.sv
verif/tb.sv
